@@ rtl/lsse_pkg.sv @@
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder - shared definitions
// Sizes, byte codes, action codes and the control bundles that pass between
// the store, the bit shifter and the top level.
// ----------------------------------------------------------------------------
package lsse_pkg;

	localparam int LED_COUNT = 64;
	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
	localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

	localparam logic [4:0] TOP_BIT = 5'd23;
	localparam logic [7:0] CODE_ONE = 8'hF0;
	localparam logic [7:0] CODE_ZERO = 8'h80;

	typedef enum logic [2:0] {
		ACT_WRITE   = 3'd0,
		ACT_FILL    = 3'd1,
		ACT_REFRESH = 3'd2,
		ACT_BLANK   = 3'd3,
		ACT_TICK    = 3'd4
	} act_t;

	// Command to the colour store.
	typedef struct packed {
		logic             write;
		logic             fill;
		logic [IDX_W-1:0] addr;
		logic [23:0]      rgb;
	} st_cmd_t;

	// Command to the bit shifter.
	typedef struct packed {
		logic        load;
		logic        shift;
		logic [23:0] grb;
	} shf_cmd_t;

	// Reorders RRGGBB into GGRRBB, the order the strip expects.
	function automatic logic [23:0] to_grb(input logic [23:0] rgb);
		return {rgb[15:8], rgb[23:16], rgb[7:0]};
	endfunction

endpackage

@@ rtl/led_strip_spi_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder - top level
// Colour store plus a serial frame sender that codes each colour bit as an
// SPI byte for a single-wire LED strip.
// ----------------------------------------------------------------------------
// A tick beat during a frame shows its byte in the output register in the
// cycle after it is accepted; writes and ticks are taken one per cycle
// while the input is not stalled. Starting a frame, and each step to the
// next entry, stalls the input while the store's registered read port
// fetches the entry. A fill stalls the input until all entries are written,
// one per cycle. Reset clears the valid bits at once, so the whole store
// reads black with no clearing pass; the memory array itself is not reset.
// ----------------------------------------------------------------------------
module led_strip_spi_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  led_index,
	input  logic [23:0] color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  spi_byte,
	output logic        frame_end
);

	// Idle takes commands, load waits for the store read, send shifts bits.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t                       st_q;
	state_t                       st_d;
	logic                         blank_q;
	logic [lsse_pkg::IDX_W-1:0]   pos_q;
	logic                         out_valid_q;
	logic [7:0]                   spi_byte_q;
	logic                         frame_end_q;

	logic                         accept;
	logic                         fill_busy;
	logic                         is_tick;
	logic                         produce;
	logic                         in_range;
	logic                         bit_out;
	logic                         last_bit;
	logic [23:0]                  rd_rgb;
	logic [lsse_pkg::IDX_W-1:0]   rd_addr;
	lsse_pkg::st_cmd_t            st_cmd;
	lsse_pkg::shf_cmd_t           shf_cmd;

	// The input is held while the store is busy filling, while an entry is
	// being fetched, and while the output register holds a beat nobody takes.
	assign in_stall = fill_busy | (st_q == ST_LOAD) | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;
	assign is_tick  = (action == lsse_pkg::ACT_TICK);
	assign in_range = ({1'b0, led_index} < lsse_pkg::LED_LIMIT);

	// Only a tick during a frame gives a result; every other action is
	// dropped while a frame is under way.
	assign produce = accept & (st_q == ST_SEND) & is_tick;

	// The next entry is always fetched ahead of the cycle it is needed: the
	// highest entry while idle, the one below the current during a frame.
	assign rd_addr = (st_q == ST_SEND) ? pos_q - 1'b1 : lsse_pkg::LAST_IDX;

	always_comb begin
		st_cmd       = '0;
		st_cmd.addr  = led_index[lsse_pkg::IDX_W-1:0];
		st_cmd.rgb   = color;
		if (accept && st_q == ST_IDLE) begin
			st_cmd.write = (action == lsse_pkg::ACT_WRITE) & in_range;
			st_cmd.fill  = (action == lsse_pkg::ACT_FILL);
		end
	end

	always_comb begin
		shf_cmd       = '0;
		shf_cmd.load  = (st_q == ST_LOAD);
		shf_cmd.shift = produce;
		shf_cmd.grb   = blank_q ? 24'd0 : lsse_pkg::to_grb(rd_rgb);
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (accept && (action == lsse_pkg::ACT_REFRESH ||
						action == lsse_pkg::ACT_BLANK)) begin
					st_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				st_d = ST_SEND;
			end
			ST_SEND: begin
				if (produce && last_bit) begin
					st_d = (pos_q == '0) ? ST_IDLE : ST_LOAD;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			blank_q     <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			out_valid_q <= produce | (out_valid_q & out_stall);
			if (st_q == ST_IDLE && st_d == ST_LOAD) begin
				blank_q <= (action == lsse_pkg::ACT_BLANK);
				pos_q   <= lsse_pkg::LAST_IDX;
			end else if (produce && last_bit && pos_q != '0) begin
				pos_q <= pos_q - 1'b1;
			end
		end
	end

	// Output payload only moves when a new beat is produced.
	always_ff @(posedge clk) begin
		if (produce) begin
			spi_byte_q  <= bit_out ? lsse_pkg::CODE_ONE : lsse_pkg::CODE_ZERO;
			frame_end_q <= last_bit & (pos_q == '0);
		end
	end

	lsse_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (st_cmd),
		.rd_addr   (rd_addr),
		.rd_rgb    (rd_rgb),
		.fill_busy (fill_busy)
	);

	lsse_shifter u_shifter (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (shf_cmd),
		.bit_out  (bit_out),
		.last_bit (last_bit)
	);

	assign out_valid = out_valid_q;
	assign spi_byte  = spi_byte_q;
	assign frame_end = frame_end_q;

	// An entry fetch always hands over to sending on the next cycle.
	a_load_to_send: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LOAD |=> st_q == ST_SEND)
		else $error("entry fetch did not hand over to sending");

	// The fill sweep only runs while no frame is in progress.
	a_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fill_busy |-> st_q == ST_IDLE)
		else $error("fill sweep overlaps a frame");

	// The final bit of the lowest entry ends the frame and flags its beat.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && last_bit && pos_q == '0) |=>
			(out_valid && frame_end && st_q == ST_IDLE))
		else $error("frame end not flagged on the last beat");

endmodule

@@ rtl/lsse_store.sv @@
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder - colour store
// One-write, one-read memory of colour entries with a registered read port,
// per-entry valid bits so that unwritten entries read as black, and a
// sequential fill sweep that writes one entry per cycle.
// ----------------------------------------------------------------------------
module lsse_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsse_pkg::st_cmd_t            cmd,
	input  logic [lsse_pkg::IDX_W-1:0]   rd_addr,
	output logic [23:0]                  rd_rgb,
	output logic                         fill_busy
);

	logic [23:0]                 mem [lsse_pkg::LED_COUNT];
	logic [lsse_pkg::LED_COUNT-1:0] valid_q;
	logic                        fill_q;
	logic [lsse_pkg::IDX_W-1:0]  fill_cnt_q;
	logic [23:0]                 fill_rgb_q;
	logic [23:0]                 rd_s1;
	logic                        rd_vld_s1;
	logic                        we;
	logic [lsse_pkg::IDX_W-1:0]  waddr;
	logic [23:0]                 wdata;

	assign we    = fill_q | cmd.write;
	assign waddr = fill_q ? fill_cnt_q : cmd.addr;
	assign wdata = fill_q ? fill_rgb_q : cmd.rgb;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_vld_s1  <= 1'b0;
			fill_q     <= 1'b0;
			fill_cnt_q <= '0;
			fill_rgb_q <= '0;
		end else begin
			rd_vld_s1 <= valid_q[rd_addr];
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (fill_q) begin
				if (fill_cnt_q == lsse_pkg::LAST_IDX) begin
					fill_q <= 1'b0;
				end
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end else if (cmd.fill) begin
				fill_q     <= 1'b1;
				fill_cnt_q <= '0;
				fill_rgb_q <= cmd.rgb;
			end
		end
	end

	assign rd_rgb    = rd_vld_s1 ? rd_s1 : 24'd0;
	assign fill_busy = fill_q;

endmodule

@@ rtl/lsse_shifter.sv @@
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder - bit shifter
// Holds the word being sent and moves it out one bit per tick, most
// significant bit first, with a down counter that marks the last bit.
// ----------------------------------------------------------------------------
module lsse_shifter (
	input  logic                clk,
	input  logic                arst_n,
	input  lsse_pkg::shf_cmd_t  cmd,
	output logic                bit_out,
	output logic                last_bit
);

	logic [23:0] grb_q;
	logic [4:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grb_q <= '0;
			cnt_q <= lsse_pkg::TOP_BIT;
		end else if (cmd.load) begin
			grb_q <= cmd.grb;
			cnt_q <= lsse_pkg::TOP_BIT;
		end else if (cmd.shift) begin
			grb_q <= {grb_q[22:0], 1'b0};
			cnt_q <= (cnt_q == 5'd0) ? lsse_pkg::TOP_BIT : cnt_q - 5'd1;
		end
	end

	assign bit_out  = grb_q[23];
	assign last_bit = (cnt_q == 5'd0);

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder - testbench
// Drives actions into the encoder through the valid/stall input channel and
// checks every SPI byte beat that comes out against an in-house prediction of
// the colour store and the frame sender, with random gaps and stalls on both
// sides and one long output hold-off that backs the encoder up.
// ----------------------------------------------------------------------------
module tb;

	// A bound on the whole run, set well above what it needs at worst.
	localparam int CYCLE_LIMIT = 200_000;
	// Cycles left for stray beats once nothing more is expected.
	localparam int SETTLE_CYCLES = 16;
	// The long output hold-off starts after this many byte beats.
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 400;
	// Random actions offered after the directed table.
	localparam int RANDOM_BEATS = 925;
	localparam int MAX_REPORTS = 10;

	// Action codes that the encoder does not define.
	localparam logic [2:0] ACT_SPARE_A = 3'd5;
	localparam logic [2:0] ACT_SPARE_B = 3'd6;
	localparam logic [2:0] ACT_SPARE_C = 3'd7;

	// How a row of the directed table is checked: against the prediction,
	// as giving no byte at all, or against the byte typed into the row.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_BYTE
	} chk_t;

	typedef struct packed {
		logic [2:0]  act;
		logic [7:0]  idx;
		logic [23:0] rgb;
		chk_t        chk;
		logic [7:0]  code;
		logic        last;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} spi_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = lsse_pkg::ACT_WRITE;
	logic [7:0]  led_index = 8'h00;
	logic [23:0] color = 24'h000000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  spi_byte;
	logic        frame_end;

	led_strip_spi_frame_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.led_index (led_index),
		.color     (color),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.spi_byte  (spi_byte),
		.frame_end (frame_end)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predicted state of the encoder. The store holds RRGGBB as written; the
	// word being shifted out is held as GGRRBB, green going out first.
	// ------------------------------------------------------------------------
	logic [23:0] led_mem [lsse_pkg::LED_COUNT];
	bit          in_frame;
	bit          zero_frame;
	int          cur_led;
	logic [4:0]  cur_bit;
	logic [23:0] cur_grb;

	// Byte beats still owed by the encoder, oldest first.
	spi_beat_t   spi_bytes_due [$];

	int          mismatches;
	int          results_seen;
	int          cycles;
	bit          hold_off;
	bit          send_calm;

	// Fetches the entry at the current position, or zeros for a blank frame,
	// and points at its top bit.
	function automatic void load_entry();
		logic [23:0] rgb;
		rgb = led_mem[cur_led];
		cur_grb = zero_frame ? 24'h000000 : {rgb[15:8], rgb[23:16], rgb[7:0]};
		cur_bit = lsse_pkg::TOP_BIT;
	endfunction

	// Advances the prediction by one accepted action. Returns 1 when the
	// action produces a byte beat, which is then given in code and last.
	function automatic bit strip_step(input logic [2:0] act, input logic [7:0] idx,
			input logic [23:0] rgb, output logic [7:0] code, output logic last);
		int i;
		code = lsse_pkg::CODE_ZERO;
		last = 1'b0;
		if (in_frame) begin
			// Mid-frame, only a tick does anything.
			if (act != lsse_pkg::ACT_TICK)
				return 1'b0;
			code = cur_grb[cur_bit] ? lsse_pkg::CODE_ONE : lsse_pkg::CODE_ZERO;
			last = (cur_led == 0) && (cur_bit == 5'd0);
			if (cur_bit == 5'd0) begin
				if (cur_led == 0) begin
					in_frame = 1'b0;
					cur_bit = lsse_pkg::TOP_BIT;
				end else begin
					cur_led--;
					load_entry();
				end
			end else begin
				cur_bit--;
			end
			return 1'b1;
		end
		case (act)
			lsse_pkg::ACT_WRITE: begin
				if (idx < lsse_pkg::LED_COUNT)
					led_mem[idx] = rgb;
			end
			lsse_pkg::ACT_FILL: begin
				for (i = 0; i < lsse_pkg::LED_COUNT; i++)
					led_mem[i] = rgb;
			end
			lsse_pkg::ACT_REFRESH, lsse_pkg::ACT_BLANK: begin
				in_frame = 1'b1;
				zero_frame = (act == lsse_pkg::ACT_BLANK);
				cur_led = lsse_pkg::LED_COUNT - 1;
				load_entry();
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	// Offers one action after a random gap, waits until the encoder takes
	// it, and then records the byte beat that it owes, if any.
	task automatic offer(input logic [2:0] act_i, input logic [7:0] idx_i,
			input logic [23:0] rgb_i, input chk_t chk, input logic [7:0] code_i,
			input logic last_i);
		int        gap;
		bit        got;
		logic [7:0] code;
		logic      last;
		spi_beat_t beat;
		// Now and then switch between gappy and back-to-back stretches.
		if ($urandom_range(0, 63) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act_i;
		led_index <= idx_i;
		color <= rgb_i;
		do
			@(posedge clk);
		while (in_stall);
		got = strip_step(act_i, idx_i, rgb_i, code, last);
		case (chk)
			CHK_MODEL: begin
				if (got) begin
					beat.code = code;
					beat.last = last;
					spi_bytes_due.push_back(beat);
				end
			end
			CHK_BYTE: begin
				beat.code = code_i;
				beat.last = last_i;
				spi_bytes_due.push_back(beat);
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_beat(input string why, input spi_beat_t want,
			input logic [7:0] code, input logic last);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: %s: expected byte %02h end %0b, got byte %02h end %0b",
				$time, why, want.code, want.last, code, last);
	endtask

	// ------------------------------------------------------------------------
	// Directed table. The store is filled white, the top entry is made pure
	// green so that the first eight bytes of the refresh frame are ones and
	// the ninth a zero, and writes past the end of the store aim at indexes
	// that would alias onto the first and last entries if the encoder only
	// looked at the low address bits. Idle ticks and the undefined action
	// codes must give nothing, and so must every action but a tick once the
	// frame has started.
	// ------------------------------------------------------------------------
	stim_row_t directed_rows [25];

	initial begin
		directed_rows = '{
			'{lsse_pkg::ACT_FILL,    8'd0,   24'hFFFFFF, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_WRITE,   8'd63,  24'h00FF00, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_WRITE,   8'd0,   24'h5AC3A5, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_WRITE,   8'd255, 24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_WRITE,   8'd64,  24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{ACT_SPARE_A,           8'd1,   24'h123456, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{ACT_SPARE_B,           8'd2,   24'hFFFFFF, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{ACT_SPARE_C,           8'd3,   24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_REFRESH, 8'd0,   24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ONE,  1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_BYTE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_WRITE,   8'd63,  24'hFFFFFF, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_FILL,    8'd0,   24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_REFRESH, 8'd0,   24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_BLANK,   8'd0,   24'h000000, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{ACT_SPARE_C,           8'd255, 24'hFFFFFF, CHK_NONE,  lsse_pkg::CODE_ZERO, 1'b0},
			'{lsse_pkg::ACT_TICK,    8'd0,   24'h000000, CHK_MODEL, lsse_pkg::CODE_ZERO, 1'b0}
		};
	end

	// ------------------------------------------------------------------------
	// Sender: reset, the directed table, then a fixed number of random
	// actions.
	// ------------------------------------------------------------------------
	initial begin : sender
		int          i;
		int          pick;
		logic [2:0]  act;
		logic [7:0]  idx;
		logic [23:0] rgb;

		for (i = 0; i < lsse_pkg::LED_COUNT; i++)
			led_mem[i] = 24'h000000;
		in_frame = 1'b0;
		zero_frame = 1'b0;
		cur_led = 0;
		cur_bit = lsse_pkg::TOP_BIT;
		cur_grb = 24'h000000;
		send_calm = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			offer(directed_rows[r].act, directed_rows[r].idx, directed_rows[r].rgb,
				directed_rows[r].chk, directed_rows[r].code, directed_rows[r].last);

		// While a frame runs almost every beat is a tick, with the odd stray
		// action thrown in; between frames it is mostly writes and fills.
		for (i = 0; i < RANDOM_BEATS; i++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 4) == 0)
				rgb = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
			else
				rgb = 24'($urandom());
			if ($urandom_range(0, 6) == 0)
				idx = 8'($urandom_range(lsse_pkg::LED_COUNT, 255));
			else
				idx = 8'($urandom_range(0, lsse_pkg::LED_COUNT - 1));
			if (in_frame) begin
				if (pick < 93)
					act = lsse_pkg::ACT_TICK;
				else
					act = 3'($urandom());
			end else begin
				if (pick < 55)
					act = lsse_pkg::ACT_WRITE;
				else if (pick < 60)
					act = lsse_pkg::ACT_FILL;
				else if (pick < 66)
					act = lsse_pkg::ACT_REFRESH;
				else if (pick < 69)
					act = lsse_pkg::ACT_BLANK;
				else if (pick < 80)
					act = lsse_pkg::ACT_TICK;
				else
					act = 3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
			end
			offer(act, idx, rgb, CHK_MODEL, lsse_pkg::CODE_ZERO, 1'b0);
		end
		in_valid <= 1'b0;

		while (spi_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (spi_bytes_due.size() != 0) begin
			$display("%0d expected byte beats never arrived", spi_bytes_due.size());
			mismatches += spi_bytes_due.size();
		end
		if (mismatches == 0)
			$display("led_strip_spi_frame_encoder test passed");
		else
			$display("led_strip_spi_frame_encoder test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: takes byte beats, checks each against the oldest one owed,
	// and stalls for a random number of cycles after each beat. Quiet
	// stretches with no stalls come and go at random.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int        stall_left;
		bit        calm;
		spi_beat_t want;
		stall_left = 0;
		calm = 1'b0;
		mismatches = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (spi_bytes_due.size() == 0) begin
					want.code = lsse_pkg::CODE_ZERO;
					want.last = 1'b0;
					flag_beat("byte beat with none expected", want, spi_byte, frame_end);
				end else begin
					want = spi_bytes_due.pop_front();
					if (spi_byte !== want.code || frame_end !== want.last)
						flag_beat("byte beat mismatch", want, spi_byte, frame_end);
				end
				if ($urandom_range(0, 63) == 0)
					calm = !calm;
				stall_left = calm ? 0 : $urandom_range(0, 15);
			end
			out_stall <= hold_off || (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// One long hold-off on the output while the sender keeps offering ticks,
	// so the output register fills and the encoder has to stall its input.
	// It switches on the falling edge, away from the edges where the
	// receiver looks at it.
	initial begin : long_hold
		hold_off = 1'b0;
		wait (results_seen >= HOLD_AFTER);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycles);
			$display("led_strip_spi_frame_encoder test failed");
			$finish;
		end
	end

	initial cycles = 0;

endmodule
